// ===== rtl/lgts_pkg.sv =====
// ----------------------------------------------------------------------------
// lgts_pkg
// shared constants, types and state codes of the toroidal life grid
// ----------------------------------------------------------------------------
package lgts_pkg;

  localparam int MAX_COLS      = 32;
  localparam int MAX_ROWS      = 32;
  localparam int COL_W         = $clog2(MAX_COLS);
  localparam int ROW_W         = $clog2(MAX_ROWS);
  localparam int NC_W          = $clog2(MAX_COLS + 1);
  localparam int NR_W          = $clog2(MAX_ROWS + 1);
  localparam int CFG_W         = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int NBR_W         = 4;
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  localparam logic ACT_TOGGLE = 1'b0;
  localparam logic ACT_STEP   = 1'b1;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef struct packed {
    logic [ROW_W-1:0] rd_addr;
    logic             we;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;
  } mem_req_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b000_0001,
    S_TGL_WR   = 7'b000_0010,
    S_LD_TOP   = 7'b000_0100,
    S_LD_MID   = 7'b000_1000,
    S_CALC     = 7'b001_0000,
    S_EMIT_RD  = 7'b010_0000,
    S_EMIT_OUT = 7'b100_0000
  } state_t;

endpackage

// ===== rtl/lgts_in_if.sv =====
// ----------------------------------------------------------------------------
// lgts_in_if
// request channel: toggle or step, with the cell position of a toggle
// ----------------------------------------------------------------------------
interface lgts_in_if import lgts_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             action;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  modport source (output valid, action, row, col, input ready);
  modport sink   (input valid, action, row, col, output ready);

endinterface

// ===== rtl/lgts_out_if.sv =====
// ----------------------------------------------------------------------------
// lgts_out_if
// result channel: one grid row per transfer, with last-row and empty-grid flags
// ----------------------------------------------------------------------------
interface lgts_out_if import lgts_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  row_t             row_bits;
  logic             last_row;
  logic             grid_empty;

  modport source (output valid, row_index, row_bits, last_row, grid_empty, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, grid_empty, output ready);

endinterface

// ===== rtl/lgts_grid_mem.sv =====
// ----------------------------------------------------------------------------
// lgts_grid_mem
// grid row store, one write and one registered read per cycle,
// per-row valid bits so unwritten rows read as dead
// ----------------------------------------------------------------------------
module lgts_grid_mem import lgts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output row_t     rd_data
);

  row_t                mem_r [MAX_ROWS];
  logic [MAX_ROWS-1:0] vld_r;
  row_t                rd_q_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rd_q_r <= mem_r[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[req.rd_addr];
      if (req.we) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== rtl/lgts_rule_unit.sv =====
// ----------------------------------------------------------------------------
// lgts_rule_unit
// row-wide B3/S23 rule: next state of one row from its two wrapped
// neighbor rows, left/right wrap at the column count in use
// ----------------------------------------------------------------------------
module lgts_rule_unit import lgts_pkg::*; (
  input  row_t            top_row,
  input  row_t            mid_row,
  input  row_t            bot_row,
  input  logic [NC_W-1:0] ncols,
  output row_t            next_row
);

  function automatic row_t from_left(row_t x, logic [COL_W-1:0] lc);
    row_t y;
    y = {x[MAX_COLS-2:0], x[lc]};
    return y;
  endfunction

  function automatic row_t from_right(row_t x, logic [COL_W-1:0] lc);
    row_t y;
    y     = {1'b0, x[MAX_COLS-1:1]};
    y[lc] = x[0];
    return y;
  endfunction

  logic [COL_W-1:0] last_col;
  row_t             tl, tr, ml, mr, bl, br;
  logic [NBR_W-1:0] nbr [MAX_COLS];

  assign last_col = COL_W'(ncols - NC_W'(1));
  assign tl = from_left(top_row, last_col);
  assign tr = from_right(top_row, last_col);
  assign ml = from_left(mid_row, last_col);
  assign mr = from_right(mid_row, last_col);
  assign bl = from_left(bot_row, last_col);
  assign br = from_right(bot_row, last_col);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr[c] = NBR_W'(tl[c]) + NBR_W'(top_row[c]) + NBR_W'(tr[c])
             + NBR_W'(ml[c]) + NBR_W'(mr[c])
             + NBR_W'(bl[c]) + NBR_W'(bot_row[c]) + NBR_W'(br[c]);
      if (NC_W'(c) < ncols) begin
        next_row[c] = (nbr[c] == NBR_W'(BIRTH_COUNT))
                    | ((nbr[c] == NBR_W'(SURVIVE_COUNT)) & mid_row[c]);
      end else begin
        next_row[c] = mid_row[c];
      end
    end
  end

endmodule

// ===== rtl/life_grid_toroidal_step.sv =====
// ----------------------------------------------------------------------------
// life_grid_toroidal_step
// toroidal B3/S23 life grid, up to 32 x 32 cells, row-serial update
//
// in_ch takes one request at a time: action 0 flips the cell at row/col,
// action 1 advances one generation. ready is high only while the block is
// idle. Every request then streams all rows in use on out_ch, row 0 first,
// with last_row on the final one; on a step that row also carries grid_empty.
// cfg_we/cfg_index/cfg_wdata set the column count (index 0) and row count
// (index 1), 0 acting as 1 and values above 32 as 32; write only when idle.
// A step loads the wrapped row above row 0 and row 0 itself, then runs the
// shared rule unit once per row: one cycle a row, bounded by the single
// memory port. Each row is emitted through S_EMIT_RD (memory read), then
// S_EMIT_OUT (output register). A toggle of a cell outside the area in use
// skips the write state S_TGL_WR and streams the grid unchanged.
// A stalled receiver holds the output register and pauses the stream.
// Reset clears the grid (all dead) at once through per-row valid bits and
// sets both counts to 32.
// ----------------------------------------------------------------------------
module life_grid_toroidal_step import lgts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lgts_in_if.sink              in_ch,
  lgts_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] cols_r, rows_r;
  logic [NC_W-1:0]  nc_eff;
  logic [NR_W-1:0]  nr_eff;
  logic [ROW_W-1:0] nr_last;
  row_t             col_mask;

  logic [ROW_W-1:0] row_r, row_nxt;
  row_t             prev_r, prev_nxt;
  row_t             cur_r, cur_nxt;
  row_t             row0_r, row0_nxt;
  logic             alive_r, alive_nxt;
  logic             step_r, step_nxt;
  logic [ROW_W-1:0] tgl_row_r, tgl_row_nxt;
  logic [COL_W-1:0] tgl_col_r, tgl_col_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  row_t             out_bits_r, out_bits_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_dead_r, out_dead_nxt;

  mem_req_t         mem_req;
  row_t             rd_data;
  row_t             bot_row;
  row_t             next_row;
  row_t             emit_bits;
  logic             is_last;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_W'(MAX_COLS);
      rows_r <= CFG_W'(MAX_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cols_r <= cfg_wdata;
        CFG_ROWS: rows_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    priority if (cols_r == '0) begin
      nc_eff = NC_W'(1);
    end else if (cols_r > CFG_W'(MAX_COLS)) begin
      nc_eff = NC_W'(MAX_COLS);
    end else begin
      nc_eff = NC_W'(cols_r);
    end
    priority if (rows_r == '0) begin
      nr_eff = NR_W'(1);
    end else if (rows_r > CFG_W'(MAX_ROWS)) begin
      nr_eff = NR_W'(MAX_ROWS);
    end else begin
      nr_eff = NR_W'(rows_r);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = NC_W'(c) < nc_eff;
    end
  end

  assign nr_last   = ROW_W'(nr_eff - NR_W'(1));
  assign is_last   = (row_r == nr_last);
  assign bot_row   = is_last ? row0_r : rd_data;
  assign emit_bits = rd_data & col_mask;

  lgts_grid_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  lgts_rule_unit u_rule (
    .top_row  (prev_r),
    .mid_row  (cur_r),
    .bot_row  (bot_row),
    .ncols    (nc_eff),
    .next_row (next_row)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    row0_nxt      = row0_r;
    alive_nxt     = alive_r;
    step_nxt      = step_r;
    tgl_row_nxt   = tgl_row_r;
    tgl_col_nxt   = tgl_col_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_row_nxt   = out_row_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    out_dead_nxt  = out_dead_r;
    mem_req       = '{rd_addr: row_r, we: 1'b0, wr_addr: row_r, wr_data: next_row};

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          step_nxt    = in_ch.action;
          tgl_row_nxt = in_ch.row;
          tgl_col_nxt = in_ch.col;
          if (in_ch.action == ACT_STEP) begin
            mem_req.rd_addr = nr_last;
            state_nxt       = S_LD_TOP;
          end else begin
            mem_req.rd_addr = in_ch.row;
            if ((NR_W'(in_ch.row) < nr_eff) && (NC_W'(in_ch.col) < nc_eff)) begin
              state_nxt = S_TGL_WR;
            end else begin
              row_nxt   = '0;
              alive_nxt = 1'b0;
              state_nxt = S_EMIT_RD;
            end
          end
        end
      end
      S_TGL_WR: begin
        mem_req.we      = 1'b1;
        mem_req.wr_addr = tgl_row_r;
        mem_req.wr_data = rd_data ^ (row_t'(1) << tgl_col_r);
        row_nxt         = '0;
        alive_nxt       = 1'b0;
        state_nxt       = S_EMIT_RD;
      end
      S_LD_TOP: begin
        prev_nxt        = rd_data;
        mem_req.rd_addr = '0;
        state_nxt       = S_LD_MID;
      end
      S_LD_MID: begin
        cur_nxt         = rd_data;
        row0_nxt        = rd_data;
        mem_req.rd_addr = ROW_W'(1);
        row_nxt         = '0;
        state_nxt       = S_CALC;
      end
      S_CALC: begin
        mem_req.rd_addr = ROW_W'(row_r + ROW_W'(2));
        mem_req.we      = 1'b1;
        mem_req.wr_addr = row_r;
        mem_req.wr_data = next_row;
        prev_nxt        = cur_r;
        cur_nxt         = bot_row;
        if (is_last) begin
          row_nxt   = '0;
          alive_nxt = 1'b0;
          state_nxt = S_EMIT_RD;
        end else begin
          row_nxt = ROW_W'(row_r + ROW_W'(1));
        end
      end
      S_EMIT_RD: begin
        mem_req.rd_addr = row_r;
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_EMIT_OUT;
        end
      end
      S_EMIT_OUT: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = row_r;
        out_bits_nxt  = emit_bits;
        out_last_nxt  = is_last;
        out_dead_nxt  = is_last & step_r & ~(alive_r | (|emit_bits));
        alive_nxt     = alive_r | (|emit_bits);
        if (is_last) begin
          state_nxt = S_IDLE;
        end else begin
          row_nxt   = ROW_W'(row_r + ROW_W'(1));
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    row0_r     <= row0_nxt;
    alive_r    <= alive_nxt;
    step_r     <= step_nxt;
    tgl_row_r  <= tgl_row_nxt;
    tgl_col_r  <= tgl_col_nxt;
    out_row_r  <= out_row_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
    out_dead_r <= out_dead_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_index  = out_row_r;
  assign out_ch.row_bits   = out_bits_r;
  assign out_ch.last_row   = out_last_r;
  assign out_ch.grid_empty = out_dead_r;

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_OUT) |-> !out_valid_r)
    else $error("output register loaded while a result is pending");

  a_dead_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dead_r) |-> out_last_r)
    else $error("grid_empty set on a row that is not the last");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_row_r == nr_last)))
    else $error("last_row does not match the final row index");

  a_calc_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) |=> (state_r == S_CALC || state_r == S_EMIT_RD))
    else $error("row update left without streaming the grid");

  a_step_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && state_r != S_TGL_WR) |-> (state_r == S_CALC && row_r <= nr_last))
    else $error("grid written outside the rows in use");

endmodule
